/* rtl/core/tlb_lru_pkg.sv */
// Shared types, constants and helpers for the TLB/LRU address translator.
package tlb_lru_pkg;

    localparam int VA_W         = 16;
    localparam int PA_W         = 16;
    localparam int CNT_W        = 16;
    localparam int NEXT_FRAME_W = 9;
    localparam int SCAN_LANES   = 4;
    localparam int LANE_W       = 2;
    localparam int M_TDATA_W    = 48;
    localparam int M_TUSER_W    = 2;
    localparam int USER_HIT     = 0;
    localparam int USER_FAULT   = 1;

    localparam logic [CNT_W-1:0]        AGE_RESET      = 16'd10000;
    localparam logic [NEXT_FRAME_W-1:0] NEXT_FRAME_MAX = 9'h1FF;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic clear_en;
        logic start;
        logic scan_en;
        logic commit;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic scan_last;
        logic out_stall;
    } dp_status_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

/* rtl/core/tlb_lru_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tlb_lru_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/tlb_lru_ctrl.sv */
// Sequencing state machine: table clear, request accept, LRU scan, commit.
module tlb_lru_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    output tlb_lru_pkg::dp_cmd_t    cmd,
    input  tlb_lru_pkg::dp_status_t status
);
    import tlb_lru_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (status.scan_last) state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (!status.out_stall) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd.clear_en = 1'b0;
        cmd.start    = 1'b0;
        cmd.scan_en  = 1'b0;
        cmd.commit   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: cmd.clear_en = 1'b1;
            ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
            end
            ST_SCAN:   cmd.scan_en = 1'b1;
            ST_COMMIT: cmd.commit  = !status.out_stall;
            default: ;
        endcase
    end

endmodule

/* rtl/core/tlb_lru_dp.sv */
// Datapath: TLB entry registers, LRU scan, page table RAM, counters, result register.
module tlb_lru_dp #(
    parameter int TLB_ENTRIES = 16,
    parameter int PAGE_BITS   = 8,
    parameter int OFFSET_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tlb_lru_pkg::dp_cmd_t                cmd,
    output tlb_lru_pkg::dp_status_t             status,
    input  logic [tlb_lru_pkg::VA_W-1:0]        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tlb_lru_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [tlb_lru_pkg::M_TUSER_W-1:0]   m_tuser
);
    import tlb_lru_pkg::*;

    localparam int IW     = $clog2(TLB_ENTRIES);
    localparam int GROUPS = (TLB_ENTRIES + SCAN_LANES - 1) / SCAN_LANES;
    localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int XW     = OFFSET_BITS + PAGE_BITS + 16;
    localparam int DEPTH  = 1 << PAGE_BITS;

    // TLB entries
    logic                 tlb_valid_reg [TLB_ENTRIES];
    logic                 tlb_valid_next[TLB_ENTRIES];
    logic [PAGE_BITS-1:0] tlb_page_reg  [TLB_ENTRIES];
    logic [PAGE_BITS-1:0] tlb_page_next [TLB_ENTRIES];
    logic [PAGE_BITS-1:0] tlb_frame_reg [TLB_ENTRIES];
    logic [PAGE_BITS-1:0] tlb_frame_next[TLB_ENTRIES];
    logic [CNT_W-1:0]     tlb_age_reg   [TLB_ENTRIES];
    logic [CNT_W-1:0]     tlb_age_next  [TLB_ENTRIES];

    // request and scan state
    logic [VA_W-1:0]         va_reg, va_next;
    logic [GW-1:0]           scan_grp_reg, scan_grp_next;
    logic [CNT_W-1:0]        best_raw_age_reg, best_raw_age_next;
    logic [IW-1:0]           best_raw_idx_reg, best_raw_idx_next;
    logic [CNT_W-1:0]        best_inc_age_reg, best_inc_age_next;
    logic [IW-1:0]           best_inc_idx_reg, best_inc_idx_next;
    logic [PAGE_BITS-1:0]    clr_idx_reg, clr_idx_next;

    // counters
    logic [CNT_W-1:0]        hit_count_reg, hit_count_next;
    logic [CNT_W-1:0]        fault_count_reg, fault_count_next;
    logic [NEXT_FRAME_W-1:0] next_frame_reg, next_frame_next;

    // result register
    logic                    m_valid_reg, m_valid_next;
    logic [PA_W-1:0]         m_pa_reg, m_pa_next;
    logic                    m_hit_reg, m_hit_next;
    logic                    m_fault_reg, m_fault_next;
    logic [CNT_W-1:0]        m_hits_reg, m_hits_next;
    logic [CNT_W-1:0]        m_faults_reg, m_faults_next;

    // address split
    logic [XW-1:0]          va_ext;
    logic [PAGE_BITS-1:0]   page;
    logic [OFFSET_BITS-1:0] offset;

    assign va_ext = XW'(va_reg);
    assign page   = va_ext[OFFSET_BITS +: PAGE_BITS];
    assign offset = va_ext[OFFSET_BITS-1:0];

    // page table RAM: {valid, frame}
    logic                 ram_we;
    logic [PAGE_BITS-1:0] ram_waddr;
    logic [PAGE_BITS:0]   ram_wdata;
    logic [PAGE_BITS:0]   ram_rdata;

    tlb_lru_ram #(
        .WIDTH (PAGE_BITS + 1),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (page),
        .rdata (ram_rdata)
    );

    // LRU scan: SCAN_LANES entries per cycle, tracking the max of both the
    // current ages (fault case) and the pre-incremented ages (miss case).
    logic [GW+LANE_W-1:0] lane_idx;
    logic [CNT_W-1:0]     lane_age;
    logic [CNT_W-1:0]     lane_inc;
    logic [CNT_W-1:0]     cur_raw_age, cur_inc_age;
    logic [IW-1:0]        cur_raw_idx, cur_inc_idx;

    always_comb begin
        cur_raw_age = best_raw_age_reg;
        cur_raw_idx = best_raw_idx_reg;
        cur_inc_age = best_inc_age_reg;
        cur_inc_idx = best_inc_idx_reg;
        lane_idx    = '0;
        lane_age    = '0;
        lane_inc    = '0;
        for (int l = 0; l < SCAN_LANES; l++) begin
            lane_idx = {scan_grp_reg, LANE_W'(l)};
            if (32'(lane_idx) < 32'(TLB_ENTRIES)) begin
                lane_age = tlb_age_reg[lane_idx[IW-1:0]];
                lane_inc = sat_inc(lane_age);
                if (lane_age > cur_raw_age) begin
                    cur_raw_age = lane_age;
                    cur_raw_idx = lane_idx[IW-1:0];
                end
                if (lane_inc > cur_inc_age) begin
                    cur_inc_age = lane_inc;
                    cur_inc_idx = lane_idx[IW-1:0];
                end
            end
        end
    end

    // TLB lookup, resolved at commit
    logic [TLB_ENTRIES-1:0] match;
    logic                   hit;
    logic [PAGE_BITS-1:0]   hit_frame;
    logic                   rd_valid;
    logic [PAGE_BITS-1:0]   rd_frame;
    logic                   fault;
    logic [PAGE_BITS-1:0]   new_frame;
    logic [PAGE_BITS-1:0]   xlat_frame;
    logic [IW-1:0]          victim;
    logic [PAGE_BITS+NEXT_FRAME_W-1:0] nf_ext;
    logic [XW-1:0]          pa_ext;

    always_comb begin
        hit_frame = '0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            match[i] = tlb_valid_reg[i] && (tlb_page_reg[i] == page);
            if (match[i]) hit_frame = hit_frame | tlb_frame_reg[i];
        end
    end

    assign hit       = |match;
    assign rd_valid  = ram_rdata[PAGE_BITS];
    assign rd_frame  = ram_rdata[PAGE_BITS-1:0];
    assign fault     = !hit && !rd_valid;
    assign nf_ext    = (PAGE_BITS + NEXT_FRAME_W)'(next_frame_reg);
    assign new_frame = nf_ext[PAGE_BITS-1:0];
    assign victim    = fault ? best_raw_idx_reg : best_inc_idx_reg;
    assign pa_ext    = XW'({xlat_frame, offset});

    always_comb begin
        priority if (hit)     xlat_frame = hit_frame;
        else if (rd_valid)    xlat_frame = rd_frame;
        else                  xlat_frame = new_frame;
    end

    // RAM write: clear sweep after reset, frame install on a fault
    always_comb begin
        ram_we    = cmd.clear_en || (cmd.commit && fault);
        ram_waddr = cmd.clear_en ? clr_idx_reg : page;
        ram_wdata = cmd.clear_en ? '0 : {1'b1, new_frame};
    end

    // next-state logic
    always_comb begin
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            tlb_valid_next[i] = tlb_valid_reg[i];
            tlb_page_next[i]  = tlb_page_reg[i];
            tlb_frame_next[i] = tlb_frame_reg[i];
            tlb_age_next[i]   = tlb_age_reg[i];
            if (cmd.commit) begin
                if (hit) begin
                    tlb_age_next[i] = match[i] ? '0 : sat_inc(tlb_age_reg[i]);
                end else if (IW'(i) == victim) begin
                    tlb_valid_next[i] = 1'b1;
                    tlb_page_next[i]  = page;
                    tlb_frame_next[i] = xlat_frame;
                    tlb_age_next[i]   = '0;
                end else begin
                    tlb_age_next[i] = sat_inc(tlb_age_reg[i]);
                end
            end
        end

        va_next           = cmd.start ? s_tdata : va_reg;
        scan_grp_next     = scan_grp_reg;
        best_raw_age_next = best_raw_age_reg;
        best_raw_idx_next = best_raw_idx_reg;
        best_inc_age_next = best_inc_age_reg;
        best_inc_idx_next = best_inc_idx_reg;
        if (cmd.start) begin
            scan_grp_next     = '0;
            best_raw_age_next = '0;
            best_raw_idx_next = '0;
            best_inc_age_next = '0;
            best_inc_idx_next = '0;
        end else if (cmd.scan_en) begin
            scan_grp_next     = scan_grp_reg + 1'b1;
            best_raw_age_next = cur_raw_age;
            best_raw_idx_next = cur_raw_idx;
            best_inc_age_next = cur_inc_age;
            best_inc_idx_next = cur_inc_idx;
        end

        clr_idx_next = cmd.clear_en ? clr_idx_reg + 1'b1 : clr_idx_reg;

        hit_count_next   = hit_count_reg;
        fault_count_next = fault_count_reg;
        next_frame_next  = next_frame_reg;
        if (cmd.commit && hit) hit_count_next = sat_inc(hit_count_reg);
        if (cmd.commit && fault) begin
            fault_count_next = sat_inc(fault_count_reg);
            next_frame_next  = (next_frame_reg == NEXT_FRAME_MAX) ?
                               next_frame_reg : next_frame_reg + 1'b1;
        end

        m_valid_next  = m_valid_reg && !m_tready;
        m_pa_next     = m_pa_reg;
        m_hit_next    = m_hit_reg;
        m_fault_next  = m_fault_reg;
        m_hits_next   = m_hits_reg;
        m_faults_next = m_faults_reg;
        if (cmd.commit) begin
            m_valid_next  = 1'b1;
            m_pa_next     = pa_ext[PA_W-1:0];
            m_hit_next    = hit;
            m_fault_next  = fault;
            m_hits_next   = hit_count_next;
            m_faults_next = fault_count_next;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                tlb_valid_reg[i] <= 1'b0;
                tlb_age_reg[i]   <= AGE_RESET;
            end
            scan_grp_reg    <= '0;
            clr_idx_reg     <= '0;
            hit_count_reg   <= '0;
            fault_count_reg <= '0;
            next_frame_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                tlb_valid_reg[i] <= tlb_valid_next[i];
                tlb_age_reg[i]   <= tlb_age_next[i];
            end
            scan_grp_reg    <= scan_grp_next;
            clr_idx_reg     <= clr_idx_next;
            hit_count_reg   <= hit_count_next;
            fault_count_reg <= fault_count_next;
            next_frame_reg  <= next_frame_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            tlb_page_reg[i]  <= tlb_page_next[i];
            tlb_frame_reg[i] <= tlb_frame_next[i];
        end
        va_reg           <= va_next;
        best_raw_age_reg <= best_raw_age_next;
        best_raw_idx_reg <= best_raw_idx_next;
        best_inc_age_reg <= best_inc_age_next;
        best_inc_idx_reg <= best_inc_idx_next;
        m_pa_reg         <= m_pa_next;
        m_hit_reg        <= m_hit_next;
        m_fault_reg      <= m_fault_next;
        m_hits_reg       <= m_hits_next;
        m_faults_reg     <= m_faults_next;
    end

    assign status.clear_last = (clr_idx_reg == '1);
    assign status.scan_last  = (scan_grp_reg == GW'(GROUPS - 1));
    assign status.out_stall  = m_valid_reg && !m_tready;

    assign m_tvalid            = m_valid_reg;
    assign m_tdata             = {m_faults_reg, m_hits_reg, m_pa_reg};
    assign m_tuser[USER_HIT]   = m_hit_reg;
    assign m_tuser[USER_FAULT] = m_fault_reg;

endmodule

/* rtl/core/tlb_lru_address_translator.sv */
// Top level of the TLB/LRU demand-paging address translator.
// Each request carries a 16-bit virtual address: the low OFFSET_BITS bits are
// the offset, the next PAGE_BITS bits the page. The page is looked up in a
// TLB_ENTRIES-entry TLB kept in registers, then in a page table RAM holding
// {valid, frame} per page. A page not yet resident is faulted in with the next
// sequential frame (counter stops at 511, frame is its low PAGE_BITS bits),
// written to the page table and loaded into the LRU TLB entry. On a TLB miss
// or fault the entry with the largest age is replaced, lowest index on a tie.
// Ages and hit/fault totals saturate at 65535. One result per request.
// After reset the page table is swept clear, all 2**PAGE_BITS entries (256
// by default), with s_tready low. Each request is then accepted, walked by the
// LRU max search in groups of four TLB ages (the page table read overlaps
// it) and committed. Requests are handled one at a time. The result sits in
// an output register, so a new request is accepted while it waits on m_tready.
module tlb_lru_address_translator #(
    parameter int TLB_ENTRIES = 16,
    parameter int PAGE_BITS   = 8,
    parameter int OFFSET_BITS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request: virtual_address
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tlb_lru_pkg::VA_W-1:0]      s_tdata,   // [15:0] virtual_address
    // result
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tlb_lru_pkg::M_TDATA_W-1:0] m_tdata,   // [15:0] physical_address,
                                                         // [31:16] hit_total,
                                                         // [47:32] fault_total
    output logic [tlb_lru_pkg::M_TUSER_W-1:0] m_tuser    // [0] tlb_hit, [1] page_fault
);
    import tlb_lru_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: clear sweep, accept, scan, commit
    tlb_lru_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // TLB, page table, counters and result register
    tlb_lru_dp #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .PAGE_BITS   (PAGE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
